// File: hdl/pdc_pkg.sv
// Package for the packet destination classifier: class codes, protocol words,
// and the record passed from the front end to the back end. No dependencies.
package pdc_pkg;
  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_BCAST   = 3'd1;
  localparam logic [2:0] CLS_MCAST   = 3'd2;
  localparam logic [2:0] CLS_LOCAL   = 3'd3;
  localparam logic [2:0] CLS_REMOTE  = 3'd4;
  localparam logic [2:0] CLS_MINE    = 3'd5;

  localparam logic [1:0] KIND_V4 = 2'd1;
  localparam logic [1:0] KIND_V6 = 2'd2;

  localparam logic [15:0] PROTO_V4 = 16'h0800;
  localparam logic [15:0] PROTO_V6 = 16'h86DD;

  localparam logic [16:0] POS_LIMIT = 17'd65539;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  // config register indexes
  localparam logic [0:0] REG_TAP_MODE  = 1'b0;
  localparam logic [0:0] REG_LOCAL_MAC = 1'b1;

  typedef struct packed {
    logic [2:0]  pkt_class;
    logic [15:0] payload_len;
  } pdc_rec_t;
endpackage

// File: hdl/pdc_if.sv
// Valid/ready channel interfaces for the classifier's input and result beats.
// Depends on nothing.
interface pdc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [2:0]  entry_index;
  logic [1:0]  entry_kind;
  logic [63:0] entry_addr_hi;
  logic [63:0] entry_addr_lo;
  logic [63:0] entry_mask_hi;
  logic [63:0] entry_mask_lo;
  modport source (output valid, cmd, data_byte, last_byte, entry_index, entry_kind,
                  entry_addr_hi, entry_addr_lo, entry_mask_hi, entry_mask_lo,
                  input ready);
  modport sink (input valid, cmd, data_byte, last_byte, entry_index, entry_kind,
                entry_addr_hi, entry_addr_lo, entry_mask_hi, entry_mask_lo,
                output ready);
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pkt_class;
  logic [15:0] payload_len;
  logic [31:0] class_count;
  logic [31:0] total_count;
  modport source (output valid, pkt_class, payload_len, class_count, total_count,
                  input ready);
  modport sink (input valid, pkt_class, payload_len, class_count, total_count,
                output ready);
endinterface

// File: hdl/pdc_front.sv
// Front end: byte capture, address table, classification at packet end.
// Depends on pdc_pkg.
module pdc_front import pdc_pkg::*; #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tap_mode,
  input  logic [47:0] local_mac,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [2:0]  entry_index,
  input  logic [1:0]  entry_kind,
  input  logic [63:0] entry_addr_hi,
  input  logic [63:0] entry_addr_lo,
  input  logic [63:0] entry_mask_hi,
  input  logic [63:0] entry_mask_lo,
  output logic        rec_valid,
  input  logic        rec_ready,
  output pdc_rec_t    rec
);
  logic [16:0] pos;
  logic [15:0] proto_word;
  logic [47:0] mac_cap;
  logic [31:0] v4_cap;
  logic [63:0] cap_hi, cap_lo;
  logic [1:0]  tkind [TABLE_ENTRIES];
  logic [63:0] ta_hi [TABLE_ENTRIES];
  logic [63:0] ta_lo [TABLE_ENTRIES];
  logic [63:0] tm_hi [TABLE_ENTRIES];
  logic [63:0] tm_lo [TABLE_ENTRIES];

  // stage 2: finished packet, classified next cycle
  logic        s_valid;
  logic [15:0] s_plen;
  logic        s_tap;
  logic [47:0] s_mac;
  logic [15:0] s_proto;
  logic [31:0] s_v4;
  logic [63:0] s_hi, s_lo;

  logic acc;
  logic s_adv;
  logic [16:0] pos_inc;
  logic [16:0] p;
  logic [2:0]  cls;

  assign s_adv    = !s_valid || rec_ready;
  assign in_ready = s_adv;
  assign acc      = in_valid && in_ready;
  assign pos_inc  = (pos < POS_LIMIT) ? pos + 17'd1 : pos;
  assign p        = pos - 17'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; proto_word <= '0; mac_cap <= '0; v4_cap <= '0;
      cap_hi <= '0; cap_lo <= '0; s_valid <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) tkind[i] <= '0;
    end else begin
      if (acc && cmd == CMD_BYTE && last_byte) s_valid <= 1'b1;
      else if (s_adv) s_valid <= 1'b0;
      if (acc && cmd == CMD_ENTRY) begin
        if (32'(entry_index) < TABLE_ENTRIES) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (32'(entry_index) == i) begin
              tkind[i] <= entry_kind;
              ta_hi[i] <= entry_addr_hi; ta_lo[i] <= entry_addr_lo;
              tm_hi[i] <= entry_mask_hi; tm_lo[i] <= entry_mask_lo;
            end
          end
        end
      end else if (acc) begin
        if (pos == 17'd2 || pos == 17'd3) proto_word <= {proto_word[7:0], data_byte};
        else if (pos >= 17'd4) begin
          if (p < 17'd6)  mac_cap <= {mac_cap[39:0], data_byte};
          if (p >= 17'd16 && p < 17'd20) v4_cap <= {v4_cap[23:0], data_byte};
          if (p >= 17'd24 && p < 17'd32) cap_hi <= {cap_hi[55:0], data_byte};
          if (p >= 17'd32 && p < 17'd40) cap_lo <= {cap_lo[55:0], data_byte};
        end
        if (last_byte) begin
          pos <= '0; proto_word <= '0; mac_cap <= '0; v4_cap <= '0;
          cap_hi <= '0; cap_lo <= '0;
        end else pos <= pos_inc;
      end
    end
  end

  // snapshot of the finished packet; byte of last beat folded in
  always_ff @(posedge clk) begin
    if (acc && cmd == CMD_BYTE && last_byte) begin
      s_tap   <= tap_mode;
      s_plen  <= (pos_inc > 17'd65539) ? 16'hFFFF :
                 (pos_inc > 17'd4) ? 16'(pos_inc - 17'd4) : 16'd0;
      s_proto <= (pos == 17'd3) ? {proto_word[7:0], data_byte} : proto_word;
      s_mac   <= (pos >= 17'd4 && p < 17'd6) ? {mac_cap[39:0], data_byte} : mac_cap;
      s_v4    <= (pos >= 17'd4 && p >= 17'd16 && p < 17'd20) ?
                 {v4_cap[23:0], data_byte} : v4_cap;
      s_hi    <= (pos >= 17'd4 && p >= 17'd24 && p < 17'd32) ?
                 {cap_hi[55:0], data_byte} : cap_hi;
      s_lo    <= (pos >= 17'd4 && p >= 17'd32 && p < 17'd40) ?
                 {cap_lo[55:0], data_byte} : cap_lo;
    end
  end

  always_comb begin
    logic found;
    logic [31:0] a, m;
    cls = CLS_UNKNOWN;
    found = 1'b0;
    a = '0; m = '0;
    if (s_plen == 16'd0) cls = CLS_UNKNOWN;
    else if (s_tap) begin
      if (s_plen < 16'd12) cls = CLS_UNKNOWN;
      else if (s_mac == local_mac) cls = CLS_MINE;
      else if (s_mac[40]) cls = (s_mac == 48'hFFFFFFFFFFFF) ? CLS_BCAST : CLS_MCAST;
      else cls = CLS_LOCAL;
    end else if (s_proto == PROTO_V4) begin
      if (s_plen < 16'd20) cls = CLS_UNKNOWN;
      else if (s_v4 == 32'hFFFFFFFF) cls = CLS_BCAST;
      else if ((s_v4 & 32'hF0000000) == 32'hE0000000) cls = CLS_MCAST;
      else begin
        cls = CLS_REMOTE;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          a = ta_lo[i][31:0]; m = tm_lo[i][31:0];
          if (!found && tkind[i] == KIND_V4) begin
            if (a == s_v4) begin cls = CLS_MINE; found = 1'b1; end
            else if ((a & m) == (s_v4 & m)) begin
              cls = ((s_v4 & ~m) == ~m) ? CLS_BCAST : CLS_LOCAL;
              found = 1'b1;
            end
          end
        end
      end
    end else if (s_proto == PROTO_V6) begin
      if (s_plen < 16'd40) cls = CLS_UNKNOWN;
      else if (s_hi[63:56] == 8'hFF) cls = CLS_MCAST;
      else begin
        cls = CLS_REMOTE;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!found && tkind[i] == KIND_V6) begin
            if (ta_hi[i] == s_hi && ta_lo[i] == s_lo) begin
              cls = CLS_MINE; found = 1'b1;
            end else if (((ta_hi[i] ^ s_hi) & tm_hi[i]) == '0 &&
                         ((ta_lo[i] ^ s_lo) & tm_lo[i]) == '0) begin
              cls = CLS_LOCAL; found = 1'b1;
            end
          end
        end
      end
    end
  end

  assign rec_valid       = s_valid;
  assign rec.pkt_class   = cls;
  assign rec.payload_len = s_plen;
endmodule

// File: hdl/pdc_back.sv
// Back end: two-entry queue of classified packets, counters, result register.
// Depends on pdc_pkg.
module pdc_back import pdc_pkg::*; #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  output logic        rec_ready,
  input  pdc_rec_t    rec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  pkt_class,
  output logic [15:0] payload_len,
  output logic [31:0] class_count,
  output logic [31:0] total_count
);
  pdc_rec_t q [2];
  logic [1:0] cnt;
  logic       rd;
  logic [COUNTER_WIDTH-1:0] ctr [7];
  logic [COUNTER_WIDTH-1:0] cnew, tnew;
  logic       push, pop;

  assign rec_ready = cnt != 2'd2;
  assign push = rec_valid && rec_ready;
  assign pop  = cnt != 2'd0 && (!out_valid || out_ready);
  assign cnew = ctr[q[rd].pkt_class] + 1'b1;
  assign tnew = ctr[6] + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; out_valid <= 1'b0;
      for (int i = 0; i < 7; i++) ctr[i] <= '0;
    end else begin
      if (pop) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      // write slot is the head when empty, else right behind it, whatever the pop does
      if (push) q[rd ^ (cnt != 2'd0)] <= rec;
      if (pop) begin
        rd <= ~rd;
        ctr[q[rd].pkt_class] <= cnew;
        ctr[6] <= tnew;
        pkt_class   <= q[rd].pkt_class;
        payload_len <= q[rd].payload_len;
        class_count <= 32'(cnew);
        total_count <= 32'(tnew);
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hdl/packet_destination_classifier_top.sv
// Top level of the packet destination classifier: APB registers and the
// front/back split. Depends on pdc_pkg, pdc_if, pdc_front and pdc_back.
//
// Usage:
//  - in_ch carries one beat per cycle while in_ch.ready is high: cmd 0 is a packet
//    byte (tunnel header first), cmd 1 loads one slot of the local address table.
//  - out_ch gives one beat per packet, on its last byte: class, payload length
//    and the new class and total counter values.
//  - APB: tap_mode at 0x0, local_mac at 0x8; write only while idle.
// Throughput: one input beat per cycle while in_ch.ready is high. The result beat
// passes the capture snapshot with table match, a queue slot and the result reg
// before it goes valid.
// The front end matches all table slots in parallel from a registered
// snapshot; a two-entry queue feeds the counter stage.
// Reset (synchronous): table invalid, counters zero, registers zero.
// When the receiver stalls, the queue fills, then in_ch.ready drops.
module packet_destination_classifier_top import pdc_pkg::*; #(
  parameter int TABLE_ENTRIES = 8,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  pdc_in_if.sink      in_ch,
  pdc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic        tap_mode;
  logic [47:0] local_mac;
  logic        rec_valid, rec_ready;
  pdc_rec_t    rec;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_mode <= 1'b0; local_mac <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2:0] == 3'd0 && paddr[3] == REG_TAP_MODE) tap_mode <= pwdata[0];
      if (paddr[2:0] == 3'd0 && paddr[3] == REG_LOCAL_MAC) local_mac <= pwdata[47:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      if (paddr[3] == REG_TAP_MODE) prdata = {63'd0, tap_mode};
      else prdata = {16'd0, local_mac};
    end
  end

  pdc_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk, .rst, .tap_mode, .local_mac,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .cmd(in_ch.cmd),
    .data_byte(in_ch.data_byte), .last_byte(in_ch.last_byte),
    .entry_index(in_ch.entry_index), .entry_kind(in_ch.entry_kind),
    .entry_addr_hi(in_ch.entry_addr_hi), .entry_addr_lo(in_ch.entry_addr_lo),
    .entry_mask_hi(in_ch.entry_mask_hi), .entry_mask_lo(in_ch.entry_mask_lo),
    .rec_valid, .rec_ready, .rec
  );

  pdc_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
    .clk, .rst, .rec_valid, .rec_ready, .rec,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .pkt_class(out_ch.pkt_class), .payload_len(out_ch.payload_len),
    .class_count(out_ch.class_count), .total_count(out_ch.total_count)
  );
endmodule

// File: bench/tb_packet_destination_classifier_top.sv
// Testbench for packet_destination_classifier_top: drives packet bytes and table loads,
// predicts each packet's class and counters, checks result beats in order.
// Depends on pdc_pkg, pdc_if and the RTL top level.
`timescale 1ns / 100ps

class pdc_scoreboard;
  typedef struct packed {
    logic [2:0]  pkt_class;
    logic [15:0] payload_len;
    logic [31:0] class_count;
    logic [31:0] total_count;
  } pdc_result_t;

  // mirrored state
  bit          tap_mode;
  bit [47:0]   local_mac;
  bit [16:0]   pos;
  bit [15:0]   proto;
  bit [47:0]   mac_cap;
  bit [31:0]   v4_cap;
  bit [63:0]   v6_hi, v6_lo;
  bit [1:0]    kind [8];
  bit [63:0]   a_hi [8], a_lo [8], m_hi [8], m_lo [8];
  bit [31:0]   counters [7];
  pdc_result_t pending [$];
  int          mismatches;

  function void clear_pkt();
    pos = 0; proto = 0; mac_cap = 0; v4_cap = 0; v6_hi = 0; v6_lo = 0;
  endfunction

  function bit [2:0] match_v4(bit [31:0] ip);
    if (ip == 32'hFFFF_FFFF) return pdc_pkg::CLS_BCAST;
    if ((ip & 32'hF000_0000) == 32'hE000_0000) return pdc_pkg::CLS_MCAST;
    for (int i = 0; i < 8; i++) begin
      if (kind[i] != pdc_pkg::KIND_V4) continue;
      if (a_lo[i][31:0] == ip) return pdc_pkg::CLS_MINE;
      if ((a_lo[i][31:0] & m_lo[i][31:0]) == (ip & m_lo[i][31:0])) begin
        if ((ip & ~m_lo[i][31:0]) == ~m_lo[i][31:0]) return pdc_pkg::CLS_BCAST;
        return pdc_pkg::CLS_LOCAL;
      end
    end
    return pdc_pkg::CLS_REMOTE;
  endfunction

  function bit [2:0] match_v6();
    if (v6_hi[63:56] == 8'hFF) return pdc_pkg::CLS_MCAST;
    for (int i = 0; i < 8; i++) begin
      if (kind[i] != pdc_pkg::KIND_V6) continue;
      if (a_hi[i] == v6_hi && a_lo[i] == v6_lo) return pdc_pkg::CLS_MINE;
      if ((a_hi[i] & m_hi[i]) == (v6_hi & m_hi[i]) &&
          (a_lo[i] & m_lo[i]) == (v6_lo & m_lo[i])) return pdc_pkg::CLS_LOCAL;
    end
    return pdc_pkg::CLS_REMOTE;
  endfunction

  function bit [2:0] classify(bit [15:0] plen);
    if (plen == 0) return pdc_pkg::CLS_UNKNOWN;
    if (tap_mode) begin
      if (plen < 12) return pdc_pkg::CLS_UNKNOWN;
      if (mac_cap == local_mac) return pdc_pkg::CLS_MINE;
      if (mac_cap[40]) begin
        if (mac_cap == 48'hFFFF_FFFF_FFFF) return pdc_pkg::CLS_BCAST;
        return pdc_pkg::CLS_MCAST;
      end
      return pdc_pkg::CLS_LOCAL;
    end
    if (proto == pdc_pkg::PROTO_V4) begin
      if (plen < 20) return pdc_pkg::CLS_UNKNOWN;
      return match_v4(v4_cap);
    end
    if (proto == pdc_pkg::PROTO_V6) begin
      if (plen < 40) return pdc_pkg::CLS_UNKNOWN;
      return match_v6();
    end
    return pdc_pkg::CLS_UNKNOWN;
  endfunction

  function void reset_state();
    tap_mode = 0; local_mac = 0; clear_pkt();
    for (int i = 0; i < 8; i++) kind[i] = 0;
    for (int i = 0; i < 7; i++) counters[i] = 0;
    mismatches = 0;
  endfunction

  // note one accepted input beat
  function void note_beat(bit cmd, bit [7:0] b, bit last, bit [2:0] idx, bit [1:0] k,
                          bit [63:0] ah, bit [63:0] al, bit [63:0] mh, bit [63:0] ml);
    bit [15:0]   plen;
    bit [16:0]   p;
    pdc_result_t r;
    if (cmd == pdc_pkg::CMD_ENTRY) begin
      kind[idx] = k; a_hi[idx] = ah; a_lo[idx] = al; m_hi[idx] = mh; m_lo[idx] = ml;
      return;
    end
    if (pos == 2 || pos == 3) proto = {proto[7:0], b};
    else if (pos >= 4) begin
      p = pos - 4;
      if (p < 6) mac_cap = {mac_cap[39:0], b};
      if (p >= 16 && p < 20) v4_cap = {v4_cap[23:0], b};
      if (p >= 24 && p < 32) v6_hi = {v6_hi[55:0], b};
      if (p >= 32 && p < 40) v6_lo = {v6_lo[55:0], b};
    end
    if (pos < pdc_pkg::POS_LIMIT) pos++;
    if (!last) return;
    plen = (pos > 4) ? ((pos - 4 > 17'hFFFF) ? 16'hFFFF : 16'(pos - 4)) : 16'd0;
    r.pkt_class = classify(plen);
    r.payload_len = plen;
    counters[r.pkt_class]++;
    counters[6]++;
    r.class_count = counters[r.pkt_class];
    r.total_count = counters[6];
    pending = {pending, r};
    clear_pkt();
  endfunction

  function void check_result(pdc_result_t got);
    pdc_result_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: exp cls %0d len %0d cc %0d tc %0d, got cls %0d len %0d cc %0d tc %0d",
                 exp.pkt_class, exp.payload_len, exp.class_count, exp.total_count,
                 got.pkt_class, got.payload_len, got.class_count, got.total_count);
    end
  endfunction
endclass

module tb_packet_destination_classifier_top;
  import pdc_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam logic [3:0] ADDR_TAP = 4'h0;  // 64-bit spacing since local_mac is 48 bits
  localparam logic [3:0] ADDR_MAC = 4'h8;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [63:0] pwdata = 0;
  logic [63:0] prdata;
  logic        pready;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();

  packet_destination_classifier_top u_dut (
    .clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  pdc_scoreboard sb = new();
  int  idle_stall_pct = 8;  // source and sink idle percentage
  int  cycles         = 0;
  int  quiet_end      = 0;  // no idling on either side before this cycle
  int  stuck          = 0;
  int  sent           = 0;

  // sink side: random stalls, checks every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.pkt_class, out_ch.payload_len,
                       out_ch.class_count, out_ch.total_count});
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= (cycles < quiet_end) || ($urandom_range(99) >= idle_stall_pct);
  end

  // watchdog: cycles with no beat accepted on either channel
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_TAP) sb.tap_mode = data[0];
    else sb.local_mac = data[47:0];
  endtask

  // one input beat; holds valid across back-to-back beats
  task automatic send_beat(input bit cmd, input bit [7:0] b, input bit last,
                           input bit [2:0] idx = 0, input bit [1:0] k = 0,
                           input bit [63:0] ah = 0, input bit [63:0] al = 0,
                           input bit [63:0] mh = 0, input bit [63:0] ml = 0);
    while (cycles >= quiet_end && $urandom_range(99) < idle_stall_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.cmd <= cmd; in_ch.data_byte <= b; in_ch.last_byte <= last;
    in_ch.entry_index <= idx; in_ch.entry_kind <= k; in_ch.entry_addr_hi <= ah;
    in_ch.entry_addr_lo <= al; in_ch.entry_mask_hi <= mh; in_ch.entry_mask_lo <= ml;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_beat(cmd, b, last, idx, k, ah, al, mh, ml);
    sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // drain: no new beats until every predicted result arrived, plus latency slack
  task automatic drain();
    end_burst();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_entry(bit [2:0] idx, bit [1:0] k, bit [63:0] ah, bit [63:0] al,
                            bit [63:0] mh, bit [63:0] ml);
    send_beat(CMD_ENTRY, 8'($urandom), 1'($urandom), idx, k, ah, al, mh, ml);
  endtask

  // packet with a given protocol word and destination bytes; length is payload bytes
  task automatic send_packet(bit [15:0] proto, int plen, bit [7:0] dst [40],
                             bit interleave = 0);
    bit [7:0] b;
    for (int i = 0; i < plen + 4; i++) begin
      if (i == 0 || i == 1) b = 8'($urandom);
      else if (i == 2) b = proto[15:8];
      else if (i == 3) b = proto[7:0];
      else if (i - 4 < 40) b = dst[i - 4];
      else b = 8'($urandom);
      if (interleave && i == 2)  // table write mid-packet must not disturb it
        load_entry(3'($urandom_range(7)), 2'd3, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
      send_beat(CMD_BYTE, b, i == plen + 3);
    end
  endtask

  function automatic void fill_v4(ref bit [7:0] d [40], input bit [31:0] ip);
    for (int i = 0; i < 40; i++) d[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) d[16 + i] = ip[31 - 8*i -: 8];
  endfunction

  function automatic void fill_v6(ref bit [7:0] d [40], input bit [63:0] hi, bit [63:0] lo);
    for (int i = 0; i < 40; i++) d[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      d[24 + i] = hi[63 - 8*i -: 8];
      d[32 + i] = lo[63 - 8*i -: 8];
    end
  endfunction

  function automatic void fill_mac(ref bit [7:0] d [40], input bit [47:0] mac);
    for (int i = 0; i < 40; i++) d[i] = 8'($urandom);
    for (int i = 0; i < 6; i++) d[i] = mac[47 - 8*i -: 8];
  endfunction

  bit [31:0] v4_addr [8], v4_mask [8];
  bit [63:0] v6_ahi [8], v6_alo [8], v6_mhi [8], v6_mlo [8];

  function automatic bit [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // random table: mix of v4, v6, invalid and kind 3 slots
  task automatic load_table();
    bit [1:0] k;
    int pfx;
    for (int i = 0; i < 8; i++) begin
      k = 2'($urandom_range(3));
      pfx = $urandom_range(32);
      v4_mask[i] = (pfx == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> pfx);
      v4_addr[i] = $urandom;
      v6_ahi[i] = rnd64(); v6_alo[i] = rnd64();
      pfx = $urandom_range(128);
      {v6_mhi[i], v6_mlo[i]} = (pfx == 0) ? 128'h0 : ~({128{1'b1}} >> pfx);
      if (k == KIND_V4)
        load_entry(3'(i), k, rnd64(), {$urandom, v4_addr[i]}, rnd64(),
                   {$urandom, v4_mask[i]});
      else
        load_entry(3'(i), k, v6_ahi[i], v6_alo[i], v6_mhi[i], v6_mlo[i]);
    end
  endtask

  // random packet, mostly well formed and aimed at table entries
  task automatic random_packet();
    bit [7:0]  d [40];
    bit [15:0] proto;
    bit [31:0] ip;
    bit [63:0] hi, lo;
    int        s, plen, pick;
    s = $urandom_range(7);
    pick = $urandom_range(9);
    if (sb.tap_mode) begin
      case (pick % 5)
        0: fill_mac(d, sb.local_mac);
        1: fill_mac(d, 48'hFFFF_FFFF_FFFF);
        default: fill_mac(d, 48'({$urandom, $urandom}));
      endcase
      proto = 16'($urandom);
    end else begin
      proto = ($urandom_range(9) < 5) ? PROTO_V4 : PROTO_V6;
      if (pick == 0) proto = 16'($urandom);
      case ($urandom_range(6))
        0: ip = v4_addr[s];
        1: ip = (v4_addr[s] & v4_mask[s]) | ~v4_mask[s];
        2: ip = (v4_addr[s] & v4_mask[s]) | ($urandom & ~v4_mask[s]);
        3: ip = 32'hFFFF_FFFF;
        4: ip = {4'hE, 28'($urandom)};
        default: ip = $urandom;
      endcase
      case ($urandom_range(4))
        0: begin hi = v6_ahi[s]; lo = v6_alo[s]; end
        1: begin
          hi = (v6_ahi[s] & v6_mhi[s]) | (rnd64() & ~v6_mhi[s]);
          lo = (v6_alo[s] & v6_mlo[s]) | (rnd64() & ~v6_mlo[s]);
        end
        2: begin hi = {8'hFF, 56'(rnd64())}; lo = rnd64(); end
        default: begin hi = rnd64(); lo = rnd64(); end
      endcase
      if (proto == PROTO_V6) fill_v6(d, hi, lo);
      else fill_v4(d, ip);
    end
    case ($urandom_range(9))
      0: plen = $urandom_range(0, 12);
      1: plen = $urandom_range(10, 42);
      default: plen = $urandom_range(40, 60);
    endcase
    if ($urandom_range(9) == 0 && plen >= 4) plen = plen - int'($urandom_range(4));
    send_packet(proto, plen, d, $urandom_range(19) == 0);
  endtask

  initial begin
    bit [7:0] d [40];
    int n;
    in_ch.valid = 0; in_ch.cmd = 0; in_ch.data_byte = 0; in_ch.last_byte = 0;
    in_ch.entry_index = 0; in_ch.entry_kind = 0; in_ch.entry_addr_hi = 0;
    in_ch.entry_addr_lo = 0; in_ch.entry_mask_hi = 0; in_ch.entry_mask_lo = 0;
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: IP mode, table with one v4 and one v6 subnet
    apb_write(ADDR_TAP, 64'd0);
    apb_write(ADDR_MAC, 64'h0000_FFFF_FFFF_FFFF);
    v4_addr[0] = 32'hC0A8_0105; v4_mask[0] = 32'hFFFF_FF00;
    load_entry(3'd0, KIND_V4, 64'h0, {32'h0, v4_addr[0]}, 64'h0, {32'h0, v4_mask[0]});
    load_entry(3'd7, KIND_V6, 64'h2001_0DB8_0000_0000, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    load_entry(3'd1, 2'd3, 64'h0, 64'h0, 64'h0, 64'h0);
    fill_v4(d, 32'hC0A8_0105); send_packet(PROTO_V4, 20, d);  // own address
    fill_v4(d, 32'hC0A8_01FF); send_packet(PROTO_V4, 20, d);  // subnet broadcast
    fill_v4(d, 32'hC0A8_0133); send_packet(PROTO_V4, 25, d);  // local
    fill_v4(d, 32'h0A00_0001); send_packet(PROTO_V4, 20, d);  // remote
    fill_v4(d, 32'hFFFF_FFFF); send_packet(PROTO_V4, 20, d);  // limited broadcast
    fill_v4(d, 32'hEFFF_0001); send_packet(PROTO_V4, 20, d, 1);  // multicast
    fill_v4(d, 32'hC0A8_0105); send_packet(PROTO_V4, 19, d);  // runt
    fill_v6(d, 64'h2001_0DB8_0000_0000, 64'h1); send_packet(PROTO_V6, 40, d);
    fill_v6(d, 64'h2001_0DB8_0000_0000, 64'h99); send_packet(PROTO_V6, 40, d);
    fill_v6(d, 64'hFF02_0000_0000_0000, 64'h1); send_packet(PROTO_V6, 40, d);
    fill_v6(d, 64'h2001_0DB8_0000_0000, 64'h1); send_packet(PROTO_V6, 39, d);  // runt
    send_packet(16'h1234, 45, d);   // unknown protocol
    send_packet(PROTO_V4, 0, d);    // header only
    send_beat(CMD_BYTE, 8'hFF, 1);  // one-byte packet
    drain();

    // directed: Ethernet mode, own MAC is all ones so broadcast hits own first
    apb_write(ADDR_TAP, 64'd1);
    fill_mac(d, 48'hFFFF_FFFF_FFFF); send_packet(16'h0, 12, d);
    drain();
    apb_write(ADDR_MAC, 64'h0000_0211_2233_4455);
    fill_mac(d, 48'hFFFF_FFFF_FFFF); send_packet(16'h0, 12, d);
    fill_mac(d, 48'h0211_2233_4455); send_packet(16'h0, 14, d);
    fill_mac(d, 48'h0100_5E00_0001); send_packet(16'h0, 12, d);
    fill_mac(d, 48'h0000_0000_0000); send_packet(16'h0, 11, d);
    fill_mac(d, 48'h0A00_0000_0001); send_packet(16'h0, 60, d);
    drain();

    // random phases over several register settings until the beat budget is used
    n = 0;
    while (sent < 850) begin
      apb_write(ADDR_TAP, 64'(n % 2 == 1));
      apb_write(ADDR_MAC, (n == 2) ? 64'h0 : (n == 3) ? 64'hFFFF_FFFF_FFFF
                                    : {$urandom, $urandom});
      load_table();
      if (n == 1) quiet_end = cycles + 400;
      for (int p = 0; p < 3; p++) random_packet();
      drain();
      n++;
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
